// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 hasher core
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = $clog2(QDEPTH);

	// what the front hands to the back
	typedef enum logic [1:0] {
		OP_WORD  = 2'd0,  // one packed 32-bit schedule word
		OP_PAD   = 2'd1,  // finish the message: pad and emit
		OP_NONE  = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] word;     // OP_WORD: big-endian word; OP_PAD: partial word bytes
		logic [1:0]  nbytes;   // OP_PAD: bytes valid in partial word
		logic [3:0]  widx;     // word slot in block
		logic [60:0] count;    // OP_PAD: byte count of message
	} qent_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [3:0] LEN_WORD = 4'd14; // word slot where the length starts (byte 56)

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ===== rtl/core/sha_if.sv =====
// ----------------------------------------------------------------------------
// sha_if
// valid/ready channel interfaces for byte input and digest output
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       has_byte;
	logic       last;
	modport source (output valid, msg_byte, has_byte, last, input ready);
	modport sink (input valid, msg_byte, has_byte, last, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// packs message bytes into big-endian words and counts the message length
// ----------------------------------------------------------------------------
module sha_front (
	input  logic          clk,
	input  logic          arst_n,
	sha_in_if.sink        in_ch,
	output sha_pkg::qent_t ent,
	output logic          ent_valid,
	input  logic          ent_ready
);
	import sha_pkg::*;

	logic [23:0] part_q;    // bytes of the word being packed
	logic [60:0] count_q;
	logic        word_sent_q; // full word of a last request already queued

	logic [1:0]  bpos;
	logic [31:0] word_n;
	logic [60:0] count_n;
	logic        fills;
	logic        split;

	assign bpos = count_q[1:0];
	assign count_n = count_q + 61'd1;
	assign fills = in_ch.has_byte && (bpos == 2'd3);
	// a last request that completes a word queues the word first, then the pad
	assign split = in_ch.last && fills && !word_sent_q;

	always_comb begin
		unique case (bpos)
			2'd0: word_n = {in_ch.msg_byte, 24'd0};
			2'd1: word_n = {part_q[23:16], in_ch.msg_byte, 16'd0};
			2'd2: word_n = {part_q[23:8], in_ch.msg_byte, 8'd0};
			default: word_n = {part_q, in_ch.msg_byte};
		endcase
	end

	// an item with a full word or a last flag needs a queue slot
	assign in_ch.ready = !split && (ent_ready || !(fills || in_ch.last));
	assign ent_valid = in_ch.valid && (fills || in_ch.last);

	always_comb begin
		ent = '0;
		ent.op = (in_ch.last && !split) ? OP_PAD : OP_WORD;
		ent.word = in_ch.has_byte ? word_n : {part_q, 8'd0};
		ent.widx = count_q[5:2];
		ent.count = in_ch.has_byte ? count_n : count_q;
		ent.nbytes = ent.count[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			word_sent_q <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.last)
					count_q <= '0;
				else if (in_ch.has_byte)
					count_q <= count_n;
			end
			if (in_ch.valid && split && ent_ready)
				word_sent_q <= 1'b1;
			else if (in_ch.valid && in_ch.ready)
				word_sent_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready && in_ch.has_byte)
			part_q <= word_n[31:8];
	end
endmodule

// ===== rtl/core/sha_queue.sv =====
// ----------------------------------------------------------------------------
// sha_queue
// short fifo between the front and the compression engine
// ----------------------------------------------------------------------------
module sha_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::qent_t wr_ent,
	input  logic           wr_valid,
	output logic           wr_ready,
	output sha_pkg::qent_t rd_ent,
	output logic           rd_valid,
	input  logic           rd_ready
);
	import sha_pkg::*;

	qent_t        mem_q [QDEPTH];
	logic [QAW:0] wp_q, rp_q;

	assign wr_ready = (wp_q - rp_q) != (QAW + 1)'(QDEPTH);
	assign rd_valid = wp_q != rp_q;
	assign rd_ent = mem_q[rp_q[QAW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= wp_q + 1'b1;
			if (rd_valid && rd_ready) rp_q <= rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q[QAW-1:0]] <= wr_ent;
	end
endmodule

// ===== rtl/core/sha_back.sv =====
// ----------------------------------------------------------------------------
// sha_back
// block buffer, padding, 64-round compression and digest output
// ----------------------------------------------------------------------------
module sha_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::qent_t ent,
	input  logic           ent_valid,
	output logic           ent_ready,
	sha_out_if.source      out_ch
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		ST_FILL, ST_PADW, ST_ROUND, ST_ADD, ST_EMIT
	} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];      // schedule window, w_q[0] oldest
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  rnd_q;
	logic [3:0]  pw_q;          // padding word slot
	logic [60:0] cnt_q;
	logic        padding_q;     // finishing the message
	logic        lenblk_q;      // current pad block carries the length
	logic [2:0]  oidx_q;

	logic [31:0] wnew, t1, t2, pw_word;
	logic [63:0] bits;

	assign wnew = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ KTAB[rnd_q] + w_q[0];
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign bits = {cnt_q, 3'b000};

	always_comb begin
		if (lenblk_q && pw_q == LEN_WORD) pw_word = bits[63:32];
		else if (lenblk_q && pw_q == LEN_WORD + 4'd1) pw_word = bits[31:0];
		else pw_word = '0;
	end

	assign ent_ready = (state_q == ST_FILL);
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.digest_word = h_q[oidx_q];
	assign out_ch.word_index = oidx_q;
	assign out_ch.last_word = (oidx_q == 3'd7);

	// word that holds the 0x80 byte
	logic [31:0] padded;
	always_comb begin
		unique case (ent.nbytes)
			2'd0: padded = {PAD_BYTE, 24'd0};
			2'd1: padded = {ent.word[31:24], PAD_BYTE, 16'd0};
			2'd2: padded = {ent.word[31:16], PAD_BYTE, 8'd0};
			default: padded = {ent.word[31:8], PAD_BYTE};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			rnd_q <= '0;
			pw_q <= '0;
			padding_q <= 1'b0;
			lenblk_q <= 1'b0;
			oidx_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (ent_valid) begin
						if (ent.op == OP_WORD) begin
							w_q[ent.widx] <= ent.word;
							if (ent.widx == 4'd15) begin
								for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
								rnd_q <= '0;
								state_q <= ST_ROUND;
							end
						end else begin
							// pad op: place the partial word with 0x80; ST_PADW writes the rest
							w_q[ent.count[5:2]] <= padded;
							cnt_q <= ent.count;
							padding_q <= 1'b1;
							lenblk_q <= (ent.count[5:0] < 6'd56);
							pw_q <= ent.count[5:2] + 4'd1;
							if (ent.count[5:2] == 4'd15) begin
								for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
								rnd_q <= '0;
								state_q <= ST_ROUND;
							end else begin
								state_q <= ST_PADW;
							end
						end
					end
				end
				ST_PADW: begin
					w_q[pw_q] <= pw_word;
					pw_q <= pw_q + 4'd1;
					if (pw_q == 4'd15) begin
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						rnd_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wnew;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (!padding_q) begin
						state_q <= ST_FILL;
					end else if (!lenblk_q) begin
						// second pad block: zeros and the length
						lenblk_q <= 1'b1;
						pw_q <= '0;
						state_q <= ST_PADW;
					end else begin
						oidx_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
							padding_q <= 1'b0;
							state_q <= ST_FILL;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end
endmodule

// ===== rtl/core/sha256_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// sha-256 over a byte stream with padding and digest output
// ----------------------------------------------------------------------------
// Takes up to one byte request per cycle (has_byte marks a byte, last ends
// the message) and returns the digest as eight big-endian 32-bit words, word
// 0 first, with last_word on word 7. The front packs bytes into words and
// keeps the 61-bit byte count; it pushes one queue entry per full word and
// one for last, and stalls its input when such an entry meets a full
// four-word queue. A last request whose byte completes a word is also held
// back while it queues two entries: the word first, then the pad entry. The
// back takes one entry per cycle while filling, then compresses a block one
// round per cycle through a single round unit, followed by the chain add,
// and takes nothing meanwhile. The queue lets the front run at most 19
// bytes ahead, so for a long message the byte intake that the queue cannot
// hide adds to the 64 rounds, the add and the taking of the block's last
// word. On last the back writes the remaining padding words one per cycle
// (up to 15), compresses one or two final blocks (the second after its own
// padding words) and then holds eight digest requests until each is taken;
// the block then restarts from the initial hash values.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core (
	input  logic      clk,
	input  logic      arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch
);
	import sha_pkg::*;

	qent_t f_ent, b_ent;
	logic  f_valid, f_ready, b_valid, b_ready;

	// byte packing and length count
	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.ent(f_ent), .ent_valid(f_valid), .ent_ready(f_ready)
	);

	// decouples byte intake from compression
	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_ent(f_ent), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_ent(b_ent), .rd_valid(b_valid), .rd_ready(b_ready)
	);

	// compression and digest
	sha_back u_back (
		.clk(clk), .arst_n(arst_n),
		.ent(b_ent), .ent_valid(b_valid), .ent_ready(b_ready),
		.out_ch(out_ch)
	);
endmodule
